@@ sv/pls_pkg.sv @@
`timescale 1ns / 1ps

package pls_pkg;

   localparam int DEPTH  = 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   // request action codes
   localparam logic [2:0] ACT_PUSH_TAIL = 3'd0;
   localparam logic [2:0] ACT_PUSH_HEAD = 3'd1;
   localparam logic [2:0] ACT_INSERT    = 3'd2;
   localparam logic [2:0] ACT_POP_TAIL  = 3'd3;
   localparam logic [2:0] ACT_POP_HEAD  = 3'd4;
   localparam logic [2:0] ACT_REMOVE    = 3'd5;
   localparam logic [2:0] ACT_DUMP      = 3'd6;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SHIFT,
      S_DUMP,
      S_REPLY
   } state_type;

   // memory port requests from the sequencer
   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
   } ram_req_type;

   // load strobe and fields for the response register
   typedef struct packed {
      logic       load;
      status_type status;
      logic       last;
      logic       use_rdata;
   } resp_load_type;

endpackage

@@ sv/positional_list_store.sv @@
`timescale 1ns / 1ps

// Positional list store: an ordered list of up to DEPTH signed 32-bit values.
// Request channel (req_*): action, value, position; a word is taken when
// req_valid is high and req_stall is low. req_stall is high while a request
// is being worked on; the block handles one request at a time.
// Response channel (rsp_*): status, count, element, last; a word is taken
// when rsp_valid is high and rsp_stall is low. Every request gives one
// word, except a dump of a non-empty list, which gives one word per element
// front to back with last set on the final one.
// Timing: entries move through the element RAM one per cycle with a single
// address stepper; a dump keeps one RAM read in flight per element.
// The response register lets the next request be taken while a word waits.
// When the receiver stalls, the held word stays put and the sequencer waits
// for the register to free before loading the next word.
// Reset (synchronous, active high) empties the list and drops any pending
// word; the element RAM itself is not cleared.

module positional_list_store import pls_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_action,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [7:0]               req_position,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [4:0]               rsp_count,
   output logic signed [DATA_W-1:0] rsp_element,
   output logic                     rsp_last
);

   ram_req_type       ram;
   resp_load_type     resp;
   logic [CNT_W-1:0]  count;
   logic [DATA_W-1:0] rd_data;
   logic              out_free;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [4:0]        rsp_count_ff, rsp_count_in;
   logic [DATA_W-1:0] rsp_element_ff, rsp_element_in;
   logic              rsp_last_ff, rsp_last_in;

   // free when empty or when the held word leaves this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   pls_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_value    (req_value),
      .req_position (req_position),
      .out_free     (out_free),
      .rd_data      (rd_data),
      .ram          (ram),
      .resp         (resp),
      .count        (count)
   );

   pls_ram #(
      .DATA_W     (DATA_W),
      .ADDR_DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram.wr_en),
      .wr_addr (ram.wr_addr),
      .wr_data (ram.wr_data),
      .rd_en   (ram.rd_en),
      .rd_addr (ram.rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_element_in = rsp_element_ff;
      rsp_last_in    = rsp_last_ff;
      if (resp.load) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = resp.status;
         rsp_count_in   = 5'(count);
         rsp_element_in = resp.use_rdata ? rd_data : '0;
         rsp_last_in    = resp.last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_element_ff <= rsp_element_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_count   = rsp_count_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_last    = rsp_last_ff;

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_element) && $stable(rsp_last))
      else $error("stalled response word changed");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous one in progress");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> req_stall)
      else $error("request finished without a last word");

endmodule

@@ sv/pls_ram.sv @@
`timescale 1ns / 1ps

module pls_ram #(
   parameter int DATA_W     = 32,
   parameter int ADDR_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(ADDR_DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]             wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(ADDR_DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]             rd_data
);

   logic [DATA_W-1:0] mem_ff [ADDR_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/pls_ctrl.sv @@
`timescale 1ns / 1ps

module pls_ctrl import pls_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_action,
   input  logic [DATA_W-1:0]   req_value,
   input  logic [7:0]          req_position,
   input  logic                out_free,
   input  logic [DATA_W-1:0]   rd_data,
   output ram_req_type         ram,
   output resp_load_type       resp,
   output logic [CNT_W-1:0]    count
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [ADDR_W-1:0] slot_ff, slot_in;
   logic [DATA_W-1:0] value_ff, value_in;
   status_type        status_ff, status_in;
   logic              insert_ff, insert_in;
   logic              up_ff, up_in;
   logic              pend_ff, pend_in;
   logic              pend_last_ff, pend_last_in;

   logic              req_accept;
   logic              full, empty;
   logic [8:0]        pos9, cnt9;
   status_type        dec_status;
   state_type         dec_next;
   logic              dec_insert;
   logic [ADDR_W-1:0] dec_slot;
   logic [CNT_W-1:0]  dec_moves;
   logic [ADDR_W-1:0] step;
   logic              shift_done;
   logic              dump_issue;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign count      = count_ff;
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);
   assign pos9       = {1'b0, req_position};
   assign cnt9       = 9'(count_ff);
   // shared address stepper: +1 walking up, -1 walking down
   assign step       = up_ff ? ADDR_W'(1) : '1;
   assign shift_done = (rem_ff == '0) && !pend_ff;
   assign dump_issue = (rem_ff != '0) && !pend_ff && out_free;

   // request decode
   always_comb begin
      dec_status = ST_OK;
      dec_next   = S_REPLY;
      dec_insert = 1'b0;
      dec_slot   = '0;
      dec_moves  = '0;
      case (req_action)
         ACT_PUSH_TAIL: begin
            if (full) begin
               dec_status = ST_FULL;
            end else begin
               dec_next   = S_SHIFT;
               dec_insert = 1'b1;
               dec_slot   = ADDR_W'(count_ff);
            end
         end
         ACT_PUSH_HEAD: begin
            if (full) begin
               dec_status = ST_FULL;
            end else begin
               dec_next   = S_SHIFT;
               dec_insert = 1'b1;
               dec_moves  = count_ff;
            end
         end
         ACT_INSERT: begin
            if (pos9 == 9'd0 || pos9 > cnt9 + 9'd1) begin
               dec_status = ST_INVALID;
            end else if (full) begin
               dec_status = ST_FULL;
            end else begin
               dec_next   = S_SHIFT;
               dec_insert = 1'b1;
               dec_slot   = ADDR_W'(req_position - 8'd1);
               dec_moves  = count_ff - CNT_W'(req_position - 8'd1);
            end
         end
         ACT_POP_TAIL: begin
            if (empty) begin
               dec_status = ST_EMPTY;
            end else begin
               dec_next = S_SHIFT;
               dec_slot = ADDR_W'(count_ff - CNT_W'(1));
            end
         end
         ACT_POP_HEAD: begin
            if (empty) begin
               dec_status = ST_EMPTY;
            end else begin
               dec_next  = S_SHIFT;
               dec_moves = count_ff - CNT_W'(1);
            end
         end
         ACT_REMOVE: begin
            if (empty) begin
               dec_status = ST_EMPTY;
            end else if (pos9 == 9'd0 || pos9 > cnt9) begin
               dec_status = ST_INVALID;
            end else begin
               dec_next  = S_SHIFT;
               dec_slot  = ADDR_W'(req_position - 8'd1);
               dec_moves = count_ff - CNT_W'(req_position);
            end
         end
         ACT_DUMP: begin
            if (empty) begin
               dec_status = ST_EMPTY;
            end else begin
               dec_next  = S_DUMP;
               dec_moves = count_ff;
            end
         end
         default: begin
            dec_status = ST_OK;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = dec_next;
            end
         end
         S_SHIFT: begin
            if (shift_done) begin
               state_in = S_REPLY;
            end
         end
         S_DUMP: begin
            if (pend_ff && pend_last_ff) begin
               state_in = S_IDLE;
            end
         end
         S_REPLY: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath, memory and response control
   always_comb begin
      count_in     = count_ff;
      rem_in       = rem_ff;
      rd_addr_in   = rd_addr_ff;
      wr_addr_in   = wr_addr_ff;
      slot_in      = slot_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      insert_in    = insert_ff;
      up_in        = up_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      ram          = '0;
      ram.rd_addr  = rd_addr_ff;
      ram.wr_addr  = wr_addr_ff;
      ram.wr_data  = rd_data;
      resp         = '0;
      resp.status  = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               status_in    = dec_status;
               insert_in    = dec_insert;
               slot_in      = dec_slot;
               rem_in       = dec_moves;
               value_in     = req_value;
               pend_in      = 1'b0;
               pend_last_in = 1'b0;
               if (dec_next == S_DUMP) begin
                  rd_addr_in = '0;
                  up_in      = 1'b1;
               end else if (dec_insert) begin
                  // shift entries toward the back, highest first
                  rd_addr_in = ADDR_W'(count_ff - CNT_W'(1));
                  wr_addr_in = ADDR_W'(count_ff);
                  up_in      = 1'b0;
               end else begin
                  // pull entries toward the front, lowest first
                  rd_addr_in = dec_slot + ADDR_W'(1);
                  wr_addr_in = dec_slot;
                  up_in      = 1'b1;
               end
            end
         end
         S_SHIFT: begin
            if (rem_ff != '0) begin
               ram.rd_en  = 1'b1;
               rd_addr_in = rd_addr_ff + step;
               rem_in     = rem_ff - CNT_W'(1);
            end
            pend_in = (rem_ff != '0);
            if (pend_ff) begin
               ram.wr_en  = 1'b1;
               wr_addr_in = wr_addr_ff + step;
            end
            if (shift_done) begin
               if (insert_ff) begin
                  ram.wr_en   = 1'b1;
                  ram.wr_addr = slot_ff;
                  ram.wr_data = value_ff;
                  count_in    = count_ff + CNT_W'(1);
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         S_DUMP: begin
            // one read in flight; the response register is free when it lands
            if (dump_issue) begin
               ram.rd_en    = 1'b1;
               rd_addr_in   = rd_addr_ff + step;
               rem_in       = rem_ff - CNT_W'(1);
               pend_last_in = (rem_ff == CNT_W'(1));
            end
            pend_in        = dump_issue;
            resp.load      = pend_ff;
            resp.status    = ST_OK;
            resp.last      = pend_last_ff;
            resp.use_rdata = 1'b1;
         end
         S_REPLY: begin
            resp.load   = out_free;
            resp.status = status_ff;
            resp.last   = 1'b1;
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      rd_addr_ff <= rd_addr_in;
      wr_addr_ff <= wr_addr_in;
      slot_ff    <= slot_in;
      value_ff   <= value_in;
      status_ff  <= status_in;
      insert_ff  <= insert_in;
      up_ff      <= up_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count above capacity");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (ram.rd_en && ram.wr_en) |-> (ram.rd_addr != ram.wr_addr))
      else $error("shift reads and writes the same entry");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
      (count_ff == $past(count_ff) + CNT_W'(1) ||
       count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("element count moved by more than one");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      resp.load |-> out_free)
      else $error("response loaded while output word held");

   a_dump_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP && pend_ff) |=> !pend_ff || $past(out_free))
      else $error("dump read issued without room for the word");

endmodule

@@ tb/pls_checker.sv @@
`timescale 1ns / 1ps

module pls_checker import pls_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [2:0]               req_action,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [7:0]               req_position,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [1:0]               rsp_status,
   input  logic [4:0]               rsp_count,
   input  logic signed [DATA_W-1:0] rsp_element,
   input  logic                     rsp_last,
   output int                       words_pending,
   output int                       mismatches
);

   typedef struct packed {
      status_type               status;
      logic [4:0]               count;
      logic signed [DATA_W-1:0] element;
      logic                     last;
   } list_word_type;

   logic signed [DATA_W-1:0] list_entries [DEPTH];
   int unsigned              list_len       = 0;
   list_word_type            expected_words [$];
   int unsigned              words_seen     = 0;
   int                       mismatch_count = 0;
   int                       pending_count  = 0;

   assign mismatches    = mismatch_count;
   assign words_pending = pending_count;

   task automatic report_mismatch(input string what);
      $display("mismatch at word %0d: %s", words_seen, what);
      mismatch_count++;
   endtask

   task automatic queue_word(input status_type st, input logic signed [DATA_W-1:0] elem,
                             input logic last);
      list_word_type w;
      w.status  = st;
      w.count   = list_len[4:0];
      w.element = elem;
      w.last    = last;
      expected_words.insert(expected_words.size(), w);
   endtask

   function automatic status_type place_entry(input int unsigned slot,
                                              input logic signed [DATA_W-1:0] val);
      if (list_len >= DEPTH)
         return ST_FULL;
      for (int unsigned i = list_len; i > slot; i--)
         list_entries[i] = list_entries[i-1];
      list_entries[slot] = val;
      list_len++;
      return ST_OK;
   endfunction

   function automatic void drop_entry(input int unsigned slot);
      for (int unsigned i = slot; i + 1 < list_len; i++)
         list_entries[i] = list_entries[i+1];
      list_len--;
   endfunction

   // expected words for one accepted request, in order
   task automatic predict_list_words(input logic [2:0] act,
                                     input logic signed [DATA_W-1:0] val,
                                     input logic [7:0] pos);
      status_type st;
      st = ST_OK;
      case (act)
         ACT_PUSH_TAIL: st = place_entry(list_len, val);
         ACT_PUSH_HEAD: st = place_entry(0, val);
         ACT_INSERT: begin
            if (pos < 1 || pos > list_len + 1)
               st = ST_INVALID;
            else
               st = place_entry(int'(pos) - 1, val);
         end
         ACT_POP_TAIL: begin
            if (list_len == 0)
               st = ST_EMPTY;
            else
               drop_entry(list_len - 1);
         end
         ACT_POP_HEAD: begin
            if (list_len == 0)
               st = ST_EMPTY;
            else
               drop_entry(0);
         end
         ACT_REMOVE: begin
            // empty wins over a bad position
            if (list_len == 0)
               st = ST_EMPTY;
            else if (pos < 1 || pos > list_len)
               st = ST_INVALID;
            else
               drop_entry(int'(pos) - 1);
         end
         ACT_DUMP: begin
            if (list_len == 0) begin
               queue_word(ST_EMPTY, '0, 1'b1);
            end else begin
               for (int unsigned i = 0; i < list_len; i++)
                  queue_word(ST_OK, list_entries[i], i + 1 == list_len);
            end
            return;
         end
         default: ;
      endcase
      queue_word(st, '0, 1'b1);
   endtask

   always @(posedge clock) begin
      list_word_type w;
      if (reset) begin
         list_len = 0;
         expected_words.delete();
      end else begin
         // results first: a word never belongs to a request taken at the same edge
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word status %0d count %0d element %0d",
                                         rsp_status, rsp_count, rsp_element));
            end else begin
               w = expected_words[0];
               expected_words.delete(0);
               if (rsp_status !== w.status)
                  report_mismatch($sformatf("status %0d, expected %0d", rsp_status, w.status));
               if (rsp_count !== w.count)
                  report_mismatch($sformatf("count %0d, expected %0d", rsp_count, w.count));
               if (rsp_element !== w.element)
                  report_mismatch($sformatf("element %0d, expected %0d",
                                            rsp_element, w.element));
               if (rsp_last !== w.last)
                  report_mismatch($sformatf("last %0b, expected %0b", rsp_last, w.last));
            end
            words_seen++;
         end
         if (req_valid === 1'b1 && req_stall === 1'b0)
            predict_list_words(req_action, req_value, req_position);
      end
      pending_count <= expected_words.size();
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

// Top of the list store bench. This module only makes traffic and gives the
// verdict; pls_checker sits beside the block, follows every accepted word on
// both channels, predicts and compares.

module tb;
   import pls_pkg::*;

   // the one action code the package leaves unnamed; the block must treat it as a no-op
   localparam logic [2:0] ACT_UNUSED = 3'd7;

   localparam int HOLD_CYCLES = 300;   // long receiver hold-off
   localparam int IDLE_LIMIT  = 3000;  // watchdog: cycles with no word moving
   localparam int DRAIN_WAIT  = 40;    // end wait, meant to outlast the longest request (full dump)

   // phase biases for the random part
   localparam int BIAS_GROW   = 0;
   localparam int BIAS_SHRINK = 1;
   localparam int BIAS_MIX    = 2;

   logic                     clock        = 1'b0;
   logic                     reset        = 1'b1;
   logic                     req_valid    = 1'b0;
   logic [2:0]               req_action   = ACT_PUSH_TAIL;
   logic signed [DATA_W-1:0] req_value    = '0;
   logic [7:0]               req_position = '0;
   logic                     rsp_stall    = 1'b0;

   logic                     req_stall;
   logic                     rsp_valid;
   logic [1:0]               rsp_status;
   logic [4:0]               rsp_count;
   logic signed [DATA_W-1:0] rsp_element;
   logic                     rsp_last;

   int words_pending;
   int mismatches;

   // sender -> receiver controls; written with NBAs, sampled at the next edge
   int unsigned hold_asks = 0;
   bit          rsp_quiet = 1'b0;

   // sender-side occupancy, only used to aim positions
   int  list_len  = 0;
   bit  no_idle   = 1'b0;

   positional_list_store i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count),
      .rsp_element  (rsp_element),
      .rsp_last     (rsp_last)
   );

   pls_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_value     (req_value),
      .req_position  (req_position),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count),
      .rsp_element   (rsp_element),
      .rsp_last      (rsp_last),
      .words_pending (words_pending),
      .mismatches    (mismatches)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Receiver: random stall bursts, mostly short with a few long ones.
   // A new hold ask from the sender starts one long hold-off, counted here.
   initial begin : receiver
      int unsigned stall_left;
      int unsigned hold_served;
      int unsigned roll;
      stall_left  = 0;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (hold_asks != hold_served) begin
            hold_served = hold_asks;
            stall_left  = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
               rsp_stall <= 1'b0;
            end else begin
               rsp_stall  <= 1'b1;
               stall_left = (roll < 95) ? $urandom_range(0, 3) : $urandom_range(8, 40);
            end
         end
      end
   end

   // Watchdog: any accepted word on either side resets the idle count.
   initial begin : watchdog
      int unsigned idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            idle = 0;
         else
            idle++;
      end
      $display("positional_list_store test failed");
      $finish;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (no_idle)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // mix of corner values and random words
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return -1;
         default: return $urandom;
      endcase
   endfunction

   // mostly legal positions for the current length, some just outside, some wild
   function automatic logic [7:0] pick_position(input logic [2:0] act);
      int unsigned roll;
      int          top;
      top  = (act == ACT_INSERT) ? list_len + 1 : list_len;
      roll = $urandom_range(0, 99);
      if (roll < 75 && top >= 1)
         return 8'($urandom_range(1, top));
      if (roll < 85)
         return 8'd0;
      if (roll < 92)
         return 8'(top + 1);
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [2:0] pick_action(input int bias);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (bias == BIAS_MIX)
         return 3'($urandom_range(0, 7));
      if (bias == BIAS_GROW) begin
         if (roll < 30) return ACT_PUSH_TAIL;
         if (roll < 50) return ACT_PUSH_HEAD;
         if (roll < 75) return ACT_INSERT;
         if (roll < 80) return ACT_POP_TAIL;
         if (roll < 85) return ACT_POP_HEAD;
         if (roll < 92) return ACT_REMOVE;
         if (roll < 98) return ACT_DUMP;
         return ACT_UNUSED;
      end
      if (roll < 8)  return ACT_PUSH_TAIL;
      if (roll < 14) return ACT_PUSH_HEAD;
      if (roll < 22) return ACT_INSERT;
      if (roll < 42) return ACT_POP_TAIL;
      if (roll < 62) return ACT_POP_HEAD;
      if (roll < 88) return ACT_REMOVE;
      if (roll < 96) return ACT_DUMP;
      return ACT_UNUSED;
   endfunction

   // Offer one request word and hold it until taken. Called right after an
   // edge; with no gap the valid stays high and only the payload moves.
   task automatic send_word(input logic [2:0] act, input logic signed [DATA_W-1:0] val,
                            input logic [7:0] pos);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_value    <= val;
      req_position <= pos;
      do @(posedge clock); while (req_stall !== 1'b0);
      // keep the sender's view of the length in step
      case (act)
         ACT_PUSH_TAIL, ACT_PUSH_HEAD: if (list_len < DEPTH) list_len++;
         ACT_INSERT: if (pos >= 1 && pos <= list_len + 1 && list_len < DEPTH) list_len++;
         ACT_POP_TAIL, ACT_POP_HEAD: if (list_len > 0) list_len--;
         ACT_REMOVE: if (list_len > 0 && pos >= 1 && pos <= list_len) list_len--;
         default: ;
      endcase
   endtask

   // sender pause until every predicted word has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
   endtask

   task automatic run_phase(input int bias, input int items);
      logic [2:0] act;
      for (int n = 0; n < items; n++) begin
         act = pick_action(bias);
         send_word(act, pick_value(), pick_position(act));
      end
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      send_word(ACT_DUMP,      '0, 8'd0);     // dump of an empty list
      send_word(ACT_POP_TAIL,  '0, 8'd0);
      send_word(ACT_POP_HEAD,  '0, 8'd0);
      send_word(ACT_REMOVE,    '0, 8'd0);     // empty beats the bad position
      send_word(ACT_REMOVE,    '0, 8'd3);
      send_word(ACT_INSERT,    32'sh1234, 8'd0);  // position zero
      send_word(ACT_INSERT,    32'sh1234, 8'd2);  // past count + 1
      send_word(ACT_INSERT,    32'sh8000_0000, 8'd1);
      send_word(ACT_PUSH_TAIL, 32'sh7fff_ffff, 8'd0);
      send_word(ACT_PUSH_HEAD, -1, 8'hff);    // position ignored
      send_word(ACT_INSERT,    32'sh5555_5555, 8'd4);  // at count + 1
      send_word(ACT_INSERT,    '0, 8'd2);
      send_word(ACT_DUMP,      '0, 8'd0);
      send_word(ACT_REMOVE,    '0, 8'd0);
      send_word(ACT_REMOVE,    '0, 8'd6);     // count + 1
      send_word(ACT_REMOVE,    '0, 8'd255);
      send_word(ACT_REMOVE,    '0, 8'd3);
      send_word(ACT_UNUSED,    32'shaaaa_aaaa, 8'haa);
      send_word(ACT_POP_TAIL,  '0, 8'd0);
      send_word(ACT_POP_HEAD,  '0, 8'd0);
      send_word(ACT_DUMP,      '0, 8'd0);
      drain();

      // --- random phases ---
      run_phase(BIAS_GROW, 60);
      drain();

      // long receiver hold-off while the sender keeps pushing: block backs up
      hold_asks <= hold_asks + 1;
      no_idle = 1'b1;
      run_phase(BIAS_GROW, 12);
      no_idle = 1'b0;
      run_phase(BIAS_MIX, 38);
      drain();

      run_phase(BIAS_SHRINK, 50);
      drain();

      // stretch with no idling on either side; grow far enough to hit full
      rsp_quiet <= 1'b1;
      no_idle = 1'b1;
      run_phase(BIAS_GROW, 70);
      no_idle = 1'b0;
      rsp_quiet <= 1'b0;
      drain();

      run_phase(BIAS_MIX, 50);
      run_phase(BIAS_SHRINK, 50);
      drain();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && words_pending == 0)
         $display("positional_list_store test passed");
      else
         $display("positional_list_store test failed");
      $finish;
   end

endmodule
